>>> sv/page_translation_refcount_table_top_assert.svh
// Assertion macros used by the page translation table controller.
// Depends on nothing; included by files that assert.
`ifndef PAGE_TRANSLATION_REFCOUNT_TABLE_TOP_ASSERT_SVH
`define PAGE_TRANSLATION_REFCOUNT_TABLE_TOP_ASSERT_SVH
`define PTRT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define PTRT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> sv/ptrt_pkg.sv
// Package for the page translation table: sizes, codes and the bucket hash.
// Depends on nothing.
`timescale 1ns / 1ps
package ptrt_pkg;
	localparam int BucketCount = 1024;
	localparam int Ways = 4;
	localparam int BucketBits = $clog2(BucketCount);
	localparam int WayBits = (Ways > 1) ? $clog2(Ways) : 1;
	localparam int SlotBits = BucketBits + $clog2(Ways);
	localparam int SlotCount = BucketCount * Ways;
	localparam int PageShift = 12;
	localparam int IndexBits = 52;
	localparam int HashShift = 33;
	localparam int ObjShift = 3;
	localparam logic [63:0] HashMul = 64'hff51afd7ed558ccd;
	localparam logic [31:0] RefsMax = 32'hFFFFFFFF;
	localparam int EntryBits = 1 + 64 + IndexBits + 64 + 32;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_INSERT = 2'd1,
		FN_RELEASE = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PRESENT = 2'd1,
		ST_MISS = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	typedef struct packed {
		logic valid;
		logic [63:0] object;
		logic [IndexBits-1:0] pidx;
		logic [63:0] phys;
		logic [31:0] refs;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic hash_mul;
		logic hash_acc;
		logic hash_fin;
		logic rd_way;
		logic cmp_way;
		logic write;
		logic finish;
	} ptrt_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last_way;
		logic hit;
	} ptrt_stat_t;
endpackage

>>> sv/ptrt_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module ptrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> sv/ptrt_datapath.sv
// Datapath: key register, hash, way scan over the entry RAM and its clearing pass.
// Depends on ptrt_pkg and ptrt_ram.
`timescale 1ns / 1ps
module ptrt_datapath import ptrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ptrt_cmd_t cmd,
	output ptrt_stat_t stat,
	input logic [1:0] func,
	input logic [63:0] object_id,
	input logic [63:0] byte_offset,
	input logic [63:0] phys_addr,
	output logic [1:0] status,
	output logic [63:0] page_out,
	output logic [31:0] refs_out
);
	logic [1:0] func_q;
	logic [63:0] obj_q;
	logic [IndexBits-1:0] pidx_q;
	logic [63:0] phys_q;
	logic [63:0] key_q;
	logic [63:0] acc_q;
	logic [BucketBits-1:0] bucket_q;
	logic [WayBits-1:0] way_q;
	logic hit_q;
	logic [WayBits-1:0] hit_way_q;
	logic free_q;
	logic [WayBits-1:0] free_way_q;
	entry_t hit_ent_q;
	logic [SlotBits-1:0] clr_q;
	logic rd_pending_q;
	logic [WayBits-1:0] rd_way_q;
	logic ram_we;
	logic [SlotBits-1:0] ram_addr;
	entry_t ram_wdata;
	entry_t ram_rdata;
	logic [WayBits-1:0] wr_way;
	logic [SlotBits-1:0] rd_slot;
	logic [63:0] k0;
	logic [63:0] k2;
	logic [63:0] mul_lo;
	logic [31:0] mul_x;
	logic [1:0] st_d;
	logic [63:0] pg_d;
	logic [31:0] rf_d;
	logic wr_d;

	function automatic logic [SlotBits-1:0] slot_of(logic [BucketBits-1:0] b,
		logic [WayBits-1:0] w);
		logic [SlotBits-1:0] s;
		s = SlotBits'(b) * SlotBits'(Ways) + SlotBits'(w);
		return s;
	endfunction

	assign k0 = (object_id >> ObjShift) ^ {12'd0, byte_offset[63:PageShift]};
	assign k2 = key_q ^ (key_q >> HashShift);
	assign mul_lo = 64'(key_q[31:0]) * 64'(HashMul[31:0]);
	assign mul_x = key_q[63:32] * HashMul[31:0] + key_q[31:0] * HashMul[63:32];
	assign rd_slot = slot_of(bucket_q, way_q);

	always_comb begin
		st_d = ST_REJECT;
		pg_d = '0;
		rf_d = '0;
		wr_d = 1'b0;
		wr_way = hit_way_q;
		ram_wdata = hit_ent_q;
		if (obj_q != 64'd0) begin
			case (func_q)
				FN_LOOKUP: begin
					if (hit_q) begin
						st_d = ST_OK;
						pg_d = hit_ent_q.phys;
						rf_d = hit_ent_q.refs;
						if (hit_ent_q.refs != RefsMax) begin
							rf_d = hit_ent_q.refs + 32'd1;
							wr_d = 1'b1;
						end
						ram_wdata.refs = rf_d;
					end else begin
						st_d = ST_MISS;
					end
				end
				FN_INSERT: begin
					if (phys_q == 64'd0) begin
						st_d = ST_REJECT;
					end else if (hit_q) begin
						st_d = ST_PRESENT;
						rf_d = hit_ent_q.refs;
					end else if (free_q) begin
						st_d = ST_OK;
						wr_d = 1'b1;
						wr_way = free_way_q;
						ram_wdata = '{valid: 1'b1, object: obj_q, pidx: pidx_q, phys: phys_q,
							refs: 32'd0};
					end
				end
				FN_RELEASE: begin
					if (hit_q && hit_ent_q.refs != 32'd0) begin
						st_d = ST_OK;
						rf_d = hit_ent_q.refs - 32'd1;
						wr_d = 1'b1;
						ram_wdata.refs = rf_d;
					end else begin
						st_d = ST_MISS;
					end
				end
				default: st_d = ST_REJECT;
			endcase
		end
		if (cmd.clear) begin
			ram_wdata = '0;
		end
		ram_we = (cmd.write && wr_d) || cmd.clear;
		ram_addr = cmd.clear ? clr_q : (cmd.write ? slot_of(bucket_q, wr_way) : rd_slot);
	end

	ptrt_ram #(.Width(EntryBits), .Depth(SlotCount)) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			obj_q <= object_id;
			pidx_q <= byte_offset[63:PageShift];
			phys_q <= phys_addr;
			key_q <= k0 ^ (k0 >> HashShift);
		end
		if (cmd.hash_mul) begin
			acc_q <= mul_lo;
		end
		if (cmd.hash_acc) begin
			key_q <= acc_q + {mul_x, 32'd0};
		end
		if (cmd.hash_fin) begin
			bucket_q <= k2[BucketBits-1:0];
		end
		rd_way_q <= way_q;
		if (cmd.cmp_way && rd_pending_q && ram_rdata.valid
			&& !hit_q && ram_rdata.object == obj_q && ram_rdata.pidx == pidx_q) begin
			hit_ent_q <= ram_rdata;
			hit_way_q <= rd_way_q;
		end
		if (cmd.finish) begin
			status <= st_d;
			page_out <= pg_d;
			refs_out <= rf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			way_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			free_way_q <= '0;
			rd_pending_q <= 1'b0;
		end else begin
			rd_pending_q <= cmd.rd_way;
			if (cmd.clear) begin
				clr_q <= clr_q + SlotBits'(1);
			end
			if (cmd.hash_fin) begin
				way_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.rd_way && !stat.last_way) begin
				way_q <= way_q + WayBits'(1);
			end
			if (cmd.cmp_way && rd_pending_q) begin
				if (ram_rdata.valid) begin
					if (ram_rdata.object == obj_q && ram_rdata.pidx == pidx_q) begin
						hit_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
					free_way_q <= rd_way_q;
				end
			end
		end
	end

	assign stat.clr_done = (clr_q == SlotBits'(SlotCount - 1));
	assign stat.last_way = (way_q == WayBits'(Ways - 1));
	assign stat.hit = hit_q;
endmodule

>>> sv/ptrt_ctrl.sv
// Controller state machine sequencing hash, way scan, update and result.
// Depends on ptrt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "page_translation_refcount_table_top_assert.svh"
module ptrt_ctrl import ptrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output ptrt_cmd_t cmd,
	input ptrt_stat_t stat
);
	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_MUL, S_ACC, S_FIN, S_SCAN, S_LAST, S_UPD
	} state_t;

	state_t state_q;
	logic busy;

	assign busy = (state_q != S_IDLE);
	assign in_ready = !busy && (!out_valid || out_ready);

	always_comb begin
		cmd = '0;
		cmd.clear = (state_q == S_CLR);
		cmd.load = in_valid && in_ready;
		cmd.hash_mul = (state_q == S_MUL);
		cmd.hash_acc = (state_q == S_ACC);
		cmd.hash_fin = (state_q == S_FIN);
		cmd.rd_way = (state_q == S_SCAN);
		cmd.cmp_way = (state_q == S_SCAN) || (state_q == S_LAST);
		cmd.write = (state_q == S_UPD);
		cmd.finish = (state_q == S_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLR: if (stat.clr_done) state_q <= S_IDLE;
				S_IDLE: if (cmd.load) state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= S_FIN;
				S_FIN: state_q <= S_SCAN;
				S_SCAN: if (stat.last_way) state_q <= S_LAST;
				S_LAST: state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTRT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy, !in_ready)
	`PTRT_ASSERT_NEXT(a_upd_gives_out, clk, arst_n, state_q == S_UPD, out_valid)
	`PTRT_ASSERT_NEXT(a_load_starts, clk, arst_n, cmd.load, state_q == S_MUL)
endmodule

>>> sv/page_translation_refcount_table_top.sv
// Top level of the page translation table with reference counts.
// Depends on ptrt_pkg, ptrt_ctrl and ptrt_datapath.
// Channel | Signals                                   | Direction
// in      | in_valid in_ready func object_id ...      | into block
// out     | out_valid out_ready status page_out refs  | out of block
// A result is registered in these steps after its item is taken:
// hash multiply low half, cross terms, bucket fold, one RAM read per way of
// the set, final compare and write-back; no new item is taken before write-back.
// Results sit in an output register; a new item is taken once the block is idle and that result is taken.
// After reset a clearing pass writes all 4096 slots, taking no item.
`timescale 1ns / 1ps
module page_translation_refcount_table_top import ptrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic [63:0] object_id,
	input logic [63:0] byte_offset,
	input logic [63:0] phys_addr,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [63:0] page_out,
	output logic [31:0] refs_out
);
	ptrt_cmd_t cmd;
	ptrt_stat_t stat;

	ptrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
	);

	ptrt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .func(func),
		.object_id(object_id), .byte_offset(byte_offset), .phys_addr(phys_addr),
		.status(status), .page_out(page_out), .refs_out(refs_out)
	);
endmodule
